@@ rtl/fbfl_pkg.sv @@
// Shared widths, codes and payload types of the fixed-block free-list allocator.
package fbfl_pkg;

	localparam int ADDR_W    = 32;
	localparam int SIZE_W    = 17;
	localparam int ESIZE_W   = 18;
	localparam int CNT_W     = 11;
	localparam int IDX_W     = 10;
	localparam int OP_W      = 2;
	localparam int ST_W      = 2;
	localparam int REG_IDX_W = 2;
	localparam int DATA_W    = 32;
	localparam int EXT_W     = CNT_W + ESIZE_W;
	localparam int QUO_W     = CNT_W;
	localparam int DIV_W     = EXT_W;

	localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(64);
	localparam logic [CNT_W-1:0]  COUNT_RST = CNT_W'(1024);

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_RESET = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE   = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BASE  = 2'd0,
		REG_SIZE  = 2'd1,
		REG_COUNT = 2'd2
	} reg_t;

	typedef struct packed {
		logic               start;
		logic [DIV_W-1:0]   dividend;
		logic [ESIZE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
		logic             exact;
	} div_rsp_t;

endpackage

@@ rtl/fbfl_if.sv @@
// Command and result channel interfaces of the allocator.
interface fbfl_cmd_if import fbfl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output operation, output address, input ready);
	modport sink (input valid, input operation, input address, output ready);
endinterface

interface fbfl_res_if import fbfl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [IDX_W-1:0]  block_index;
	logic [ADDR_W-1:0] block_address;

	modport source (output valid, output status, output block_index, output block_address,
		input ready);
	modport sink (input valid, input status, input block_index, input block_address,
		output ready);
endinterface

@@ rtl/fbfl_div.sv @@
// Restoring divider, one quotient bit per cycle, for turning a byte offset into a block index.
module fbfl_div import fbfl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(QUO_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic              ge;

	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dsh_q <= DIV_W'({req.divisor, {(QUO_W-1){1'b0}}});
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.exact    = (rem_q == '0);

	property p_start_idle;
		@(posedge clk) disable iff (!arst_n) req.start |-> !busy_q;
	endproperty
	a_start_idle: assert property (p_start_idle) else $error("divider restarted while busy");

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) $rose(done_q) |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy)
		else $error("divider done without a run");

	property p_rem_bound;
		@(posedge clk) disable iff (!arst_n) rsp.done |-> (rem_q < (dsh_q << 1));
	endproperty
	a_rem_bound: assert property (p_rem_bound) else $error("divider remainder not reduced");

endmodule

@@ rtl/fixed_block_free_list_allocator_top.sv @@
// Fixed-block free-list allocator: LIFO free list of block links held in a one-port-read memory.
//
// Blocks of one size are handed out and taken back through a LIFO free list whose links sit
// in a synchronous memory of MAX_BLOCKS entries, one per block. An allocate reads the head
// link, then pops it; it reports empty without a read when the list is exhausted. A free
// of an address outside the pool is rejected after the range check; otherwise the
// byte offset is divided by the block size in an iterative divider, one quotient bit a
// cycle, before the link write. A pool reset rewrites one link a cycle. After reset is
// released, a clearing pass that writes min(1024, MAX_BLOCKS) links builds the list before
// the first command is taken; register writes are taken throughout. One command is in
// flight at a time; a result waiting in the output register does not hold up the next
// command until that command finishes. Freeing a block twice is not detected.
module fixed_block_free_list_allocator_top import fbfl_pkg::*; #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fbfl_cmd_if.sink              cmd,
	fbfl_res_if.source            res,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0]     cfg_data
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_BLOCKS - 1);
	localparam logic [IW-1:0] RST_LAST = (MAX_BLOCKS < 1024) ? IW'(MAX_BLOCKS - 1) : IW'(1023);

	typedef struct packed {
		logic          tail;
		logic [IW-1:0] link;
	} entry_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_ALLOC_RD,
		S_FREE_CHK,
		S_FREE_DIV,
		S_SWEEP,
		S_DONE
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0]  base_q;
	logic [SIZE_W-1:0]  size_q;
	logic [CNT_W-1:0]   count_q;
	logic [EXT_W-1:0]   extent_q;

	logic [IW-1:0]      head_q;
	logic               empty_q;
	logic [IW-1:0]      sweep_cnt_q;
	logic [IW-1:0]      sweep_last_q;
	logic [ADDR_W-1:0]  off_q;

	logic               out_valid_q;
	logic [ST_W-1:0]    out_status_q;
	logic [IDX_W-1:0]   out_index_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [ST_W-1:0]    pend_status_q;
	logic [IDX_W-1:0]   pend_index_q;
	logic [ADDR_W-1:0]  pend_addr_q;

	entry_t             link_mem [MAX_BLOCKS];
	entry_t             rd_q;
	logic               mem_we;
	logic               mem_re;
	logic [IW-1:0]      mem_wa;
	entry_t             mem_wd;

	logic [ESIZE_W-1:0]    eff_size;
	logic [CNT_W-1:0]      eff_n;
	logic [IW+ESIZE_W-1:0] prod;
	logic                  accept;
	logic                  slot_free;
	logic                  in_range;
	logic                  fin_valid;
	logic [ST_W-1:0]       fin_status;
	logic [IDX_W-1:0]      fin_index;
	logic [ADDR_W-1:0]     fin_addr;

	div_req_t div_req;
	div_rsp_t div_rsp;

	fbfl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		eff_size = ({1'b0, size_q} + ESIZE_W'(7)) & ~ESIZE_W'(7);
		if (eff_size == '0) begin
			eff_size = ESIZE_W'(8);
		end
		if (count_q == '0) begin
			eff_n = CNT_W'(1);
		end else if (32'(count_q) > MAX_BLOCKS) begin
			eff_n = CNT_W'(MAX_BLOCKS);
		end else begin
			eff_n = count_q;
		end
	end

	assign prod      = head_q * eff_size;
	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign slot_free = !out_valid_q || res.ready;
	assign in_range  = ({{(ADDR_W-EXT_W){1'b0}}, extent_q} > off_q);

	assign div_req.start    = (state_q == S_FREE_CHK) && in_range;
	assign div_req.dividend = off_q[DIV_W-1:0];
	assign div_req.divisor  = eff_size;

	always_comb begin
		fin_valid  = 1'b0;
		fin_status = ST_DONE;
		fin_index  = '0;
		fin_addr   = '0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_wa     = sweep_cnt_q;
		mem_wd.tail = (sweep_cnt_q == sweep_last_q);
		mem_wd.link = (sweep_cnt_q == LAST_IDX) ? '0 : sweep_cnt_q + 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_t'(cmd.operation))
						OP_ALLOC: begin
							if (empty_q) begin
								fin_valid  = 1'b1;
								fin_status = ST_EMPTY;
							end else begin
								mem_re = 1'b1;
							end
						end
						OP_FREE, OP_RESET: begin
						end
						default: begin
							fin_valid = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC_RD: begin
				fin_valid = 1'b1;
				fin_index = IDX_W'(head_q);
				fin_addr  = base_q + ADDR_W'(prod);
			end
			S_FREE_CHK: begin
				if (!in_range) begin
					fin_valid  = 1'b1;
					fin_status = ST_REJECT;
				end
			end
			S_FREE_DIV: begin
				if (div_rsp.done) begin
					fin_valid = 1'b1;
					if (div_rsp.exact) begin
						mem_we      = 1'b1;
						mem_wa      = IW'(div_rsp.quotient);
						mem_wd.tail = empty_q;
						mem_wd.link = head_q;
						fin_index   = IDX_W'(div_rsp.quotient);
					end else begin
						fin_status = ST_REJECT;
					end
				end
			end
			S_INIT: begin
				mem_we = 1'b1;
			end
			S_SWEEP: begin
				mem_we = 1'b1;
				fin_valid = (sweep_cnt_q == sweep_last_q);
			end
			S_DONE: begin
				fin_valid  = 1'b1;
				fin_status = pend_status_q;
				fin_index  = pend_index_q;
				fin_addr   = pend_addr_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= link_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			base_q        <= '0;
			size_q        <= SIZE_RST;
			count_q       <= COUNT_RST;
			extent_q      <= '0;
			head_q        <= '0;
			empty_q       <= 1'b0;
			sweep_cnt_q   <= '0;
			sweep_last_q  <= RST_LAST;
			off_q         <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= ST_DONE;
			out_index_q   <= '0;
			out_addr_q    <= '0;
			pend_status_q <= ST_DONE;
			pend_index_q  <= '0;
			pend_addr_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_t'(cfg_index))
					REG_BASE:  base_q  <= cfg_data;
					REG_SIZE:  size_q  <= cfg_data[SIZE_W-1:0];
					REG_COUNT: count_q <= cfg_data[CNT_W-1:0];
					default: begin
					end
				endcase
			end
			extent_q <= eff_n * eff_size;

			if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (op_t'(cmd.operation))
							OP_ALLOC: begin
								if (!empty_q) begin
									state_q <= S_ALLOC_RD;
								end
							end
							OP_FREE: begin
								off_q   <= cmd.address - base_q;
								state_q <= S_FREE_CHK;
							end
							OP_RESET: begin
								sweep_cnt_q  <= '0;
								sweep_last_q <= IW'(eff_n - 1'b1);
								head_q       <= '0;
								empty_q      <= 1'b0;
								state_q      <= S_SWEEP;
							end
							default: begin
							end
						endcase
					end
				end
				S_ALLOC_RD: begin
					head_q  <= rd_q.link;
					empty_q <= rd_q.tail;
				end
				S_FREE_CHK: begin
					if (in_range) begin
						state_q <= S_FREE_DIV;
					end
				end
				S_FREE_DIV: begin
					if (div_rsp.done && div_rsp.exact) begin
						head_q  <= IW'(div_rsp.quotient);
						empty_q <= 1'b0;
					end
				end
				S_INIT: begin
					sweep_cnt_q <= sweep_cnt_q + 1'b1;
					if (sweep_cnt_q == sweep_last_q) begin
						state_q <= S_IDLE;
					end
				end
				S_SWEEP: begin
					sweep_cnt_q <= sweep_cnt_q + 1'b1;
				end
				default: begin
				end
			endcase

			if (fin_valid) begin
				if (slot_free) begin
					out_valid_q  <= 1'b1;
					out_status_q <= fin_status;
					out_index_q  <= fin_index;
					out_addr_q   <= fin_addr;
					state_q      <= S_IDLE;
				end else begin
					pend_status_q <= fin_status;
					pend_index_q  <= fin_index;
					pend_addr_q   <= fin_addr;
					state_q       <= S_DONE;
				end
			end
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = out_status_q;
	assign res.block_index   = out_index_q;
	assign res.block_address = out_addr_q;

	property p_no_rw_clash;
		@(posedge clk) disable iff (!arst_n) !(mem_we && mem_re);
	endproperty
	a_no_rw_clash: assert property (p_no_rw_clash) else $error("link memory read and write clash");

	property p_div_owner;
		@(posedge clk) disable iff (!arst_n) div_rsp.done |-> (state_q == S_FREE_DIV);
	endproperty
	a_div_owner: assert property (p_div_owner) else $error("divider result with no free pending");

	property p_sweep_bound;
		@(posedge clk) disable iff (!arst_n)
			(state_q == S_INIT || state_q == S_SWEEP) |-> (sweep_cnt_q <= sweep_last_q);
	endproperty
	a_sweep_bound: assert property (p_sweep_bound) else $error("sweep ran past the pool");

	property p_empty_alloc_keeps_head;
		@(posedge clk) disable iff (!arst_n)
			(accept && cmd.operation == OP_ALLOC && empty_q) |=> ($stable(head_q) && empty_q);
	endproperty
	a_empty_alloc_keeps_head: assert property (p_empty_alloc_keeps_head)
		else $error("allocate on empty list changed the head");

	property p_result_not_lost;
		@(posedge clk) disable iff (!arst_n)
			(out_valid_q && !res.ready) |=> (out_valid_q && $stable(out_index_q));
	endproperty
	a_result_not_lost: assert property (p_result_not_lost)
		else $error("waiting result overwritten");

endmodule

@@ bench/fbfl_result_checker.sv @@
// Free-list allocator checker: tracks the pool, predicts every result and compares it.
module fbfl_result_checker import fbfl_pkg::*; #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	fbfl_cmd_if                  cmd,
	fbfl_res_if                  res,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [IDX_W-1:0]  block_index;
		logic [ADDR_W-1:0] block_address;
	} alloc_result_t;

	logic [ADDR_W-1:0] pool_base;
	logic [SIZE_W-1:0] raw_size;
	logic [CNT_W-1:0]  raw_count;
	logic [IDX_W-1:0]  head;
	logic              list_empty;
	logic [IDX_W-1:0]  next_block [MAX_BLOCKS];
	logic              tail_mark [MAX_BLOCKS];
	alloc_result_t     owed_results [$];
	int                errors = 0;

	assign fail_count = errors;

	function automatic logic [31:0] block_bytes();
		logic [31:0] sz;
		sz = (32'(raw_size) + 32'd7) & ~32'd7;
		return (sz == 32'd0) ? 32'd8 : sz;
	endfunction

	function automatic int unsigned pool_blocks();
		if (raw_count == '0) return 1;
		if (raw_count > MAX_BLOCKS) return MAX_BLOCKS;
		return raw_count;
	endfunction

	task automatic rebuild_pool();
		int unsigned n;
		n = pool_blocks();
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			next_block[i] = IDX_W'(i + 1);
			tail_mark[i] = (i + 1 >= n);
		end
		head = '0;
		list_empty = 1'b0;
	endtask

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch: got %h, want %h", $time, field, got, want);
		errors++;
	endtask

	task automatic predict_pool_op(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
		alloc_result_t r;
		logic [31:0]   sz;
		logic [31:0]   off;
		logic [63:0]   extent;
		logic [IDX_W-1:0] b;
		r = '0;
		r.status = ST_DONE;
		sz = block_bytes();
		case (op)
		OP_ALLOC: begin
			if (list_empty) begin
				r.status = ST_EMPTY;
			end else begin
				r.block_index = head;
				r.block_address = pool_base + 32'(64'(head) * 64'(sz));
				list_empty = tail_mark[head];
				head = next_block[head];
			end
		end
		OP_FREE: begin
			off = addr - pool_base;
			extent = 64'(pool_blocks()) * 64'(sz);
			if (64'(off) >= extent || off % sz != 0) begin
				r.status = ST_REJECT;
			end else begin
				b = IDX_W'(off / sz);
				next_block[b] = head;
				tail_mark[b] = list_empty;
				head = b;
				list_empty = 1'b0;
				r.block_index = b;
			end
		end
		OP_RESET: rebuild_pool();
		default: ;
		endcase
		owed_results.push_back(r);
	endtask

	task automatic check_result();
		alloc_result_t want;
		if (owed_results.size() == 0) begin
			report_mismatch("result with no item outstanding", res.block_address, '0);
			return;
		end
		want = owed_results.pop_front();
		if (res.status !== want.status)
			report_mismatch("status", 32'(res.status), 32'(want.status));
		if (res.block_index !== want.block_index)
			report_mismatch("block_index", 32'(res.block_index), 32'(want.block_index));
		if (res.block_address !== want.block_address)
			report_mismatch("block_address", res.block_address, want.block_address);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base = '0;
			raw_size = SIZE_RST;
			raw_count = COUNT_RST;
			rebuild_pool();
			owed_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_BASE:  pool_base = cfg_data;
				REG_SIZE:  raw_size = cfg_data[SIZE_W-1:0];
				REG_COUNT: raw_count = cfg_data[CNT_W-1:0];
				default: ;
				endcase
			end
			if (res.valid && res.ready) check_result();
			if (cmd.valid && cmd.ready) predict_pool_op(cmd.operation, cmd.address);
			pending <= owed_results.size();
		end
	end
endmodule

@@ bench/fixed_block_free_list_allocator_top_tb.sv @@
// Testbench top for the free-list allocator: stimulus, handshake pacing, watchdog and verdict.
module fixed_block_free_list_allocator_top_tb import fbfl_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BLOCKS  = 1024;
	localparam int QUIET_LIMIT = 8000;
	localparam int PHASE_ITEMS = 220;
	localparam int SIDE_CMD    = 0;
	localparam int SIDE_RES    = 1;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	int                   fail_count;
	int                   pending;
	int                   quiet;
	int                   gap_left [2];
	bit                   gap_calm [2];
	logic [ADDR_W-1:0]    cur_base;
	logic [SIZE_W-1:0]    cur_size;
	logic [CNT_W-1:0]     cur_count;

	fbfl_cmd_if cmd_ch ();
	fbfl_res_if res_ch ();

	fixed_block_free_list_allocator_top #(.MAX_BLOCKS(MAX_BLOCKS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fbfl_result_checker #(.MAX_BLOCKS(MAX_BLOCKS)) watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.res        (res_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// bursts of random gaps and bursts of none, picked at random per burst
	function automatic int next_gap(int side);
		if (gap_left[side] == 0) begin
			gap_calm[side] = ($urandom_range(0, 3) == 0);
			gap_left[side] = $urandom_range(20, 60);
		end
		gap_left[side]--;
		return gap_calm[side] ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic logic [31:0] pick_free_address();
		logic [31:0] sz;
		int unsigned n;
		int          k;
		sz = (32'(cur_size) + 32'd7) & ~32'd7;
		if (sz == 32'd0) sz = 32'd8;
		n = (cur_count == '0) ? 1 : (cur_count > MAX_BLOCKS) ? MAX_BLOCKS : cur_count;
		k = $urandom_range(0, 19);
		if (k < 13)
			return cur_base + sz * 32'($urandom_range(0, n - 1));
		else if (k < 15)
			return cur_base + sz * 32'($urandom_range(0, n - 1)) + 32'($urandom_range(1, sz - 1));
		else if (k < 17)
			return cur_base + sz * 32'(n) + sz * 32'($urandom_range(0, 3));
		else if (k < 18)
			return cur_base - 32'($urandom_range(1, sz));
		return $urandom();
	endfunction

	task automatic send_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
		int gap;
		gap = next_gap(SIDE_CMD);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.address <= addr;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	task automatic drain_results(int pad);
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (pad) @(posedge clk);
	endtask

	task automatic write_config(logic [31:0] b, logic [SIZE_W-1:0] s, logic [CNT_W-1:0] n);
		cfg_we <= 1'b1;
		cfg_index <= REG_BASE;
		cfg_data <= b;
		@(posedge clk);
		cfg_index <= REG_SIZE;
		cfg_data <= 32'(s);
		@(posedge clk);
		cfg_index <= REG_COUNT;
		cfg_data <= 32'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_base = b;
		cur_size = s;
		cur_count = n;
	endtask

	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = next_gap(SIDE_RES);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int r;
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.operation <= OP_ALLOC;
		cmd_ch.address <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_BASE;
		cfg_data <= '0;
		cur_base = '0;
		cur_size = SIZE_RST;
		cur_count = COUNT_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry: 1024 blocks of 64 bytes at address zero
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '1);
		send_item(OP_ALLOC, '0);
		send_item(OP_FREE, 32'd64);
		send_item(OP_ALLOC, '0);
		send_item(OP_FREE, 32'd32);
		send_item(OP_FREE, 32'd65536);
		send_item(OP_FREE, 32'd65472);
		send_item(OP_FREE, 32'hFFFF_FFFF);
		send_item(OP_UNUSED, 32'hFFFF_FFFF);
		send_item(OP_RESET, 32'h5555_AAAA);
		send_item(OP_ALLOC, '0);
		send_item(OP_FREE, '0);
		send_item(OP_FREE, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '0);

		// odd size, zero count, one-block pool near the top of the address space
		drain_results(20);
		write_config(32'hFFFF_FFC0, 17'd13, 11'd0);
		send_item(OP_RESET, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_FREE, 32'hFFFF_FFC0);
		send_item(OP_FREE, 32'hFFFF_FFD0);
		send_item(OP_FREE, 32'hFFFF_FFB8);
		send_item(OP_ALLOC, '0);

		// grow the pool without a rebuild: links stay, checks follow the new count
		drain_results(20);
		write_config(32'hFFFF_FFC0, 17'd13, 11'h7FF);
		send_item(OP_ALLOC, '0);
		send_item(OP_FREE, 32'hFFFF_FFD0);

		for (int p = 0; p < 6; p++) begin
			drain_results(20);
			case (p)
			0: write_config('0, 17'd8, 11'd1);
			1: write_config($urandom(), SIZE_W'($urandom_range(0, 17'h1FFFF)),
				CNT_W'($urandom_range(1, 40)));
			2: write_config(32'hFFFF_FFF0, 17'd65536, 11'd1024);
			3: write_config($urandom(), 17'h1FFFF, 11'h7FF);
			4: write_config($urandom(), 17'd0, 11'd0);
			default: write_config($urandom(), SIZE_W'($urandom_range(1, 8192) * 8),
				CNT_W'($urandom_range(1, 1024)));
			endcase
			if (p % 2 == 0) send_item(OP_RESET, $urandom());
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < 48) begin
					send_item(OP_ALLOC, $urandom());
				end else if (r < 90) begin
					send_item(OP_FREE, pick_free_address());
				end else if (r < 94) begin
					send_item(OP_UNUSED, $urandom());
				end else if (r < 97) begin
					send_item(OP_RESET, $urandom());
				end else begin
					drain_results(0);
					send_item(OP_ALLOC, $urandom());
				end
			end
		end

		drain_results(40);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
